@@ rtl/rita_pkg.sv @@
// Package for the radix integer-to-ASCII converter.
// Holds digit constants and the remainder-to-character function.
// No dependencies.
package rita_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int DIGIT_IDX_W = 4;
    localparam int BASE_W      = 8;
    localparam int CHAR_W      = 8;

    localparam logic [BASE_W-1:0] C_DEFAULT_BASE = 8'd10;
    localparam logic [CHAR_W-1:0] C_ASCII_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] C_ASCII_A      = 8'h41;
    localparam logic [BASE_W-1:0] C_MIN_BASE     = 8'd2;
    localparam logic [DIGIT_IDX_W-1:0] C_LAST_SLOT = DIGIT_IDX_W'(MAX_DIGITS - 1);

    // Codes run past 'Z' for remainders of 36 and above and wrap modulo 256 for remainders of 201 and above.
    function automatic logic [CHAR_W-1:0] digit_code(input logic [BASE_W-1:0] rem);
        logic [CHAR_W-1:0] code;
        if (rem < C_DEFAULT_BASE) begin
            code = C_ASCII_ZERO + rem;
        end else begin
            code = C_ASCII_A + rem - C_DEFAULT_BASE;
        end
        return code;
    endfunction

endpackage

@@ rtl/rita_if.sv @@
// Valid/ready stream interfaces for the integer-to-ASCII converter.
// Depends on rita_pkg for the character width.
interface rita_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface rita_out_if import rita_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ rtl/rita_div.sv @@
// Restoring divider for the integer-to-ASCII converter, one quotient bit per cycle.
// Depends on rita_pkg for the divisor width.
module rita_div import rita_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [BASE_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [BASE_W-1:0]     o_remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_quo;
    logic [BASE_W-1:0]     r_rem;
    logic [BASE_W-1:0]     r_divisor;

    logic [BASE_W:0] w_trial;
    logic [BASE_W:0] w_diff;
    logic            w_fits;

    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_BITS-1]};
        w_fits  = (w_trial >= {1'b0, r_divisor});
        w_diff  = w_trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_quo     <= i_dividend;
                r_divisor <= i_divisor;
                r_rem     <= '0;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[BASE_W-1:0] : w_trial[BASE_W-1:0];
                r_quo <= {r_quo[VALUE_BITS-2:0], w_fits};
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/radix_integer_to_ascii_core.sv @@
// Top level of the radix integer-to-ASCII converter.
// Depends on rita_pkg, rita_if and rita_div.
//
// Converts one unsigned value per transfer into ASCII digits in the base held in the
// configuration register (reset 10; a base of 0 or 1 converts in base 10). Digits leave
// most significant first, one output transfer each, with last_digit set on the final one;
// zero gives a single '0' and at most the 16 least significant digits are produced. Each
// digit takes one division in the shared bit-serial restoring divider, and the first digit
// is offered once all divisions for the value are done; then one digit leaves per cycle
// when the sink is ready. The input is not ready until the last digit of the previous
// value has been transferred. A base write takes effect with the next value that is
// accepted after it.
module radix_integer_to_ascii_core import rita_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_wdata,
    rita_in_if.sink           i_in,
    rita_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [BASE_W-1:0]      r_number_base;
    logic [BASE_W-1:0]      r_base;
    logic [VALUE_BITS-1:0]  r_value;
    logic                   r_div_start;
    logic [DIGIT_IDX_W-1:0] r_count;
    logic [DIGIT_IDX_W-1:0] r_idx;
    logic [CHAR_W-1:0]      r_digits [MAX_DIGITS];

    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_quotient;
    logic [BASE_W-1:0]     w_remainder;

    rita_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_value),
        .i_divisor  (r_base),
        .o_done     (w_div_done),
        .o_quotient (w_quotient),
        .o_remainder(w_remainder)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= C_DEFAULT_BASE;
        end else if (i_cfg_we) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_value     <= i_in.value;
                        r_base      <= (r_number_base < C_MIN_BASE) ? C_DEFAULT_BASE
                                                                    : r_number_base;
                        r_count     <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (w_div_done) begin
                        r_digits[r_count] <= digit_code(w_remainder);
                        r_value           <= w_quotient;
                        r_count           <= r_count + 1'b1;
                        if (w_quotient == '0 || r_count == C_LAST_SLOT) begin
                            r_idx   <= r_count;
                            r_state <= S_EMIT;
                        end else begin
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_EMIT);
    assign o_out.digit_char = r_digits[r_idx];
    assign o_out.last_digit = (r_idx == '0);

endmodule

@@ rtl/rita_checker.sv @@
// Port-level assertions for the radix integer-to-ASCII converter.
// Bound to radix_integer_to_ascii_core; uses only its ports.
module rita_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // The block never takes a new value while a digit is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a digit is offered");

    // Conversion needs at least one divide before a digit appears.
    a_no_instant_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("digit offered right after an input transfer");

    // After the final digit the block returns to taking input.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("output continued after the last digit");

    // A digit that is not the last is always followed by another one.
    a_more_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("digit string ended without a last flag");

endmodule

bind radix_integer_to_ascii_core rita_checker u_rita_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_last (o_out.last_digit)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for radix_integer_to_ascii_core: directed table, then random phases per base.
// Expected digits come from a typed table entry or a behavioral conversion function.
// Depends on rita_pkg, rita_if and the core RTL.
module testbench;
    import rita_pkg::*;

    localparam int VALUE_W      = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PCT     = 14;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_digit;

    typedef struct {
        logic [BASE_W-1:0]  radix;
        logic [VALUE_W-1:0] value;
        string              text;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [BASE_W-1:0] cfg_wdata;
    logic sink_ready = 1'b0;
    logic burst_mode = 1'b0;

    logic [BASE_W-1:0] radix_setting = C_DEFAULT_BASE;
    t_digit pending_digits[$];
    int errors = 0;
    int stall_cycles = 0;

    // An empty text means the expected digits are computed by the predictor.
    t_stim_row directed_rows[22] = '{
        '{8'd10,  16'd0,     "0"},
        '{8'd10,  16'd65535, "65535"},
        '{8'd10,  16'd9,     "9"},
        '{8'd10,  16'd10,    "10"},
        '{8'd10,  16'hAAAA,  ""},
        '{8'd10,  16'h5555,  ""},
        '{8'd0,   16'd65535, "65535"},
        '{8'd0,   16'd0,     "0"},
        '{8'd1,   16'd100,   "100"},
        '{8'd2,   16'd65535, "1111111111111111"},
        '{8'd2,   16'd32768, "1000000000000000"},
        '{8'd2,   16'd0,     "0"},
        '{8'd16,  16'd65535, "FFFF"},
        '{8'd16,  16'd48879, "BEEF"},
        '{8'd36,  16'd35,    "Z"},
        '{8'd36,  16'd36,    "10"},
        '{8'd37,  16'd36,    ""},
        '{8'd255, 16'd254,   ""},
        '{8'd255, 16'd65535, ""},
        '{8'd255, 16'd0,     "0"},
        '{8'd128, 16'd32768, ""},
        '{8'd10,  16'd1,     "1"}
    };

    rita_in_if #(.VALUE_BITS(VALUE_W)) in_if ();
    rita_out_if out_if ();

    assign out_if.ready = sink_ready;

    radix_integer_to_ascii_core #(
        .VALUE_BITS(VALUE_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        sink_ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void predict_conversion(input logic [VALUE_W-1:0] value,
                                               input logic [BASE_W-1:0] setting);
        logic [BASE_W-1:0]  radix;
        logic [VALUE_W-1:0] quotient;
        logic [BASE_W-1:0]  rem;
        logic [CHAR_W-1:0]  codes[$];
        int                 count;
        radix = (setting < C_MIN_BASE) ? C_DEFAULT_BASE : setting;
        quotient = value;
        count = 0;
        do begin
            rem = BASE_W'(quotient % radix);
            if (rem < C_DEFAULT_BASE) begin
                codes.push_front(CHAR_W'(C_ASCII_ZERO + rem));
            end else begin
                codes.push_front(CHAR_W'(C_ASCII_A + rem - C_DEFAULT_BASE));
            end
            quotient = quotient / radix;
            count++;
        end while (quotient != 0 && count < MAX_DIGITS);
        foreach (codes[i]) begin
            pending_digits.push_back('{code: codes[i], last: (i == codes.size() - 1)});
        end
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
        int i;
        while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        if (text.len() == 0) begin
            predict_conversion(value, radix_setting);
        end else begin
            for (i = 0; i < text.len(); i++) begin
                pending_digits.push_back('{code: text[i], last: (i == text.len() - 1)});
            end
        end
    endtask

    // The base register may only change once the converter has gone idle.
    task automatic set_radix(input logic [BASE_W-1:0] setting);
        in_if.valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we <= 1'b0;
        radix_setting = setting;
    endtask

    always @(posedge clk) begin
        t_digit want;
        if (rst_n === 1'b1) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_digits.size() == 0) begin
                    $display("%0t: unexpected digit: expected none, actual %h last %b",
                             $time, out_if.digit_char, out_if.last_digit);
                    errors++;
                end else begin
                    want = pending_digits.pop_front();
                    if (out_if.digit_char !== want.code) begin
                        $display("%0t: digit_char mismatch: expected %h, actual %h",
                                 $time, want.code, out_if.digit_char);
                        errors++;
                    end
                    if (out_if.last_digit !== want.last) begin
                        $display("%0t: last_digit mismatch: expected %b, actual %b",
                                 $time, want.last, out_if.last_digit);
                        errors++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int                 sent;
        int                 phase_len;
        logic [BASE_W-1:0]  next_radix;
        logic [VALUE_W-1:0] value;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].radix != radix_setting) begin
                set_radix(directed_rows[r].radix);
            end
            send_value(directed_rows[r].value, directed_rows[r].text);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(7))
                0: next_radix = 8'd0;
                1: next_radix = 8'd1;
                2: next_radix = 8'd2;
                3: next_radix = 8'd255;
                4: next_radix = 8'd16;
                5: next_radix = C_DEFAULT_BASE;
                default: next_radix = BASE_W'($urandom_range(255));
            endcase
            set_radix(next_radix);
            phase_len = $urandom_range(15, 60);
            repeat (phase_len) begin
                burst_mode = (sent >= 200 && sent < 320);
                case ($urandom_range(9))
                    0: value = VALUE_W'($urandom_range(255));
                    1: value = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
                    2: value = (VALUE_W'(1) << $urandom_range(VALUE_W - 1)) - 1'b1;
                    3: value = $urandom_range(1) ? '1 : '0;
                    default: value = VALUE_W'($urandom_range(65535));
                endcase
                send_value(value, "");
                sent++;
            end
        end
        burst_mode = 1'b0;

        in_if.valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rita_pkg.sv
rtl/rita_if.sv
rtl/rita_div.sv
rtl/radix_integer_to_ascii_core.sv
rtl/rita_checker.sv
sim/testbench.sv
